// File: rtl/core/cache_set_replacement_policy_macros.svh
// ----------------------------------------------------------------------------
// Cache set replacement policy assertion macros
// Shared assertion forms for the checker, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef CACHE_SET_REPLACEMENT_POLICY_MACROS_SVH
`define CACHE_SET_REPLACEMENT_POLICY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/csrp_pkg.sv
// ----------------------------------------------------------------------------
// Cache set replacement policy package
// Geometry, row types, codes and reset rows shared by the replacement engine.
// ----------------------------------------------------------------------------
`default_nettype none

package csrp_pkg;

  localparam int SETS        = 1024;
  localparam int WAYS        = 16;
  localparam int ROW_W       = $clog2(SETS);
  localparam int POS_W       = $clog2(WAYS);
  localparam int SET_FIELD_W = 10;
  localparam int WAY_FIELD_W = 4;
  localparam int RRPV_W      = 2;

  localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;
  localparam logic [RRPV_W-1:0] RRPV_MISS = 2'd2;
  localparam logic [RRPV_W-1:0] RRPV_HIT  = 2'd0;

  typedef logic [WAYS-1:0][POS_W-1:0]  lru_row_t;
  typedef logic [WAYS-1:0][RRPV_W-1:0] rrpv_row_t;

  typedef enum logic {
    CMD_QUERY  = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  typedef enum logic {
    POLICY_LRU   = 1'b0,
    POLICY_SRRIP = 1'b1
  } policy_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_t;

  typedef struct packed {
    cmd_t                   command;
    logic [WAY_FIELD_W-1:0] way;
    logic                   hit;
  } req_t;

  typedef struct packed {
    lru_row_t               lru_row;
    logic                   lru_we;
    rrpv_row_t              rrpv_row;
    logic                   rrpv_we;
    logic [WAY_FIELD_W-1:0] victim;
  } row_result_t;

  function automatic lru_row_t lru_reset_row();
    lru_row_t row;
    for (int w = 0; w < WAYS; w++) begin
      row[w] = POS_W'(w);
    end
    return row;
  endfunction

  function automatic rrpv_row_t rrpv_reset_row();
    rrpv_row_t row;
    for (int w = 0; w < WAYS; w++) begin
      row[w] = RRPV_MAX;
    end
    return row;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/csrp_row_logic.sv
// ----------------------------------------------------------------------------
// Cache set replacement policy row logic
// Picks the victim and builds the written-back row for one set under LRU or
// SRRIP, comparing all ways of the row in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module csrp_row_logic
  import csrp_pkg::*;
(
  input  var policy_t     policy,
  input  var req_t        req,
  input  var lru_row_t    lru_row,
  input  var rrpv_row_t   rrpv_row,
  output row_result_t     result
);

  always_comb begin
    logic [POS_W-1:0]       way_idx;
    logic                   way_ok;
    logic [POS_W-1:0]       cur;
    logic [WAYS-1:0]        hi_bits;
    logic [WAYS-1:0]        lo_bits;
    logic [WAYS-1:0]        both_bits;
    logic [RRPV_W-1:0]      top;
    logic [RRPV_W-1:0]      age;
    rrpv_row_t              aged;
    rrpv_row_t              rrpv_set;
    lru_row_t               lru_touched;
    logic [WAY_FIELD_W-1:0] lru_victim;
    logic [WAY_FIELD_W-1:0] rrip_victim;

    way_idx = POS_W'(req.way);
    way_ok  = {1'b0, req.way} < (WAY_FIELD_W + 1)'(WAYS);
    cur     = lru_row[way_idx];

    for (int w = 0; w < WAYS; w++) begin
      hi_bits[w]   = rrpv_row[w][1];
      lo_bits[w]   = rrpv_row[w][0];
      both_bits[w] = rrpv_row[w][1] & rrpv_row[w][0];
    end
    top[1] = |hi_bits;
    top[0] = top[1] ? |both_bits : |lo_bits;
    age    = RRPV_MAX - top;

    for (int w = 0; w < WAYS; w++) begin
      aged[w] = rrpv_row[w] + age;
      lru_touched[w] = (lru_row[w] < cur) ? lru_row[w] + POS_W'(1) : lru_row[w];
    end
    lru_touched[way_idx] = '0;

    rrpv_set          = rrpv_row;
    rrpv_set[way_idx] = req.hit ? RRPV_HIT : RRPV_MISS;

    lru_victim  = '0;
    rrip_victim = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (lru_row[w] == POS_W'(WAYS - 1)) begin
        lru_victim = WAY_FIELD_W'(w);
      end
      if (aged[w] == RRPV_MAX) begin
        rrip_victim = WAY_FIELD_W'(w);
      end
    end

    result.lru_row  = lru_row;
    result.lru_we   = 1'b0;
    result.rrpv_row = rrpv_row;
    result.rrpv_we  = 1'b0;
    result.victim   = '0;

    unique case (req.command)
      CMD_QUERY: begin
        if (policy == POLICY_LRU) begin
          result.victim = lru_victim;
        end else begin
          result.victim   = rrip_victim;
          result.rrpv_row = aged;
          result.rrpv_we  = 1'b1;
        end
      end
      CMD_UPDATE: begin
        if (way_ok) begin
          if (policy == POLICY_LRU) begin
            result.lru_row = lru_touched;
            result.lru_we  = 1'b1;
          end else begin
            result.rrpv_row = rrpv_set;
            result.rrpv_we  = 1'b1;
          end
        end
      end
      default: begin
        result.victim = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/cache_set_replacement_policy.sv
// ----------------------------------------------------------------------------
// Cache set replacement policy
// Replacement-state engine with true LRU and 2-bit SRRIP for a set-associative
// cache, holding one row per set in two synchronous memories.
// ----------------------------------------------------------------------------
// Each request first reads the set's row from the memories, whose read data is
// registered, and then picks the victim, builds the new row and writes it back;
// a new request is accepted only after the previous one has finished.
// A query whose result cannot enter the output register holds in the execute
// state until the register frees up. After reset the block writes the reset
// rows into both memories, one set at a time, before it accepts its first
// request; policy writes are taken at any time.
`default_nettype none

module cache_set_replacement_policy
  import csrp_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_write_en,
  input  wire                   cfg_write_data,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   command,
  input  wire [SET_FIELD_W-1:0] set_index,
  input  wire [WAY_FIELD_W-1:0] way,
  input  wire                   hit,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [WAY_FIELD_W-1:0] victim_way
);

  state_t           state;
  state_t           state_next;
  policy_t          policy;
  logic [ROW_W-1:0] clr_row;
  logic [ROW_W-1:0] req_row;
  req_t             req;

  lru_row_t         lru_mem [SETS];
  rrpv_row_t        rrpv_mem [SETS];
  lru_row_t         lru_rd;
  rrpv_row_t        rrpv_rd;

  row_result_t      result;
  logic             accept;
  logic             exec_go;
  logic             lru_we;
  logic             rrpv_we;
  logic [ROW_W-1:0] wr_row;
  lru_row_t         lru_wdata;
  rrpv_row_t        rrpv_wdata;

  assign accept  = in_valid && in_ready;
  assign exec_go = (state == ST_EXEC) &&
                   (req.command == CMD_UPDATE || !out_valid || out_ready);

  csrp_row_logic u_row_logic (
    .policy   (policy),
    .req      (req),
    .lru_row  (lru_rd),
    .rrpv_row (rrpv_rd),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_row == ROW_W'(SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (state == ST_CLEAR) begin
      clr_row <= clr_row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POLICY_SRRIP;
    end else if (cfg_write_en) begin
      policy <= policy_t'(cfg_write_data);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_row     <= set_index[ROW_W-1:0];
      req.command <= cmd_t'(command);
      req.way     <= way;
      req.hit     <= hit;
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      lru_we     = 1'b1;
      rrpv_we    = 1'b1;
      wr_row     = clr_row;
      lru_wdata  = lru_reset_row();
      rrpv_wdata = rrpv_reset_row();
    end else begin
      lru_we     = exec_go && result.lru_we;
      rrpv_we    = exec_go && result.rrpv_we;
      wr_row     = req_row;
      lru_wdata  = result.lru_row;
      rrpv_wdata = result.rrpv_row;
    end
  end

  always_ff @(posedge clk) begin
    if (lru_we) begin
      lru_mem[wr_row] <= lru_wdata;
    end
    if (accept) begin
      lru_rd <= lru_mem[set_index[ROW_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rrpv_we) begin
      rrpv_mem[wr_row] <= rrpv_wdata;
    end
    if (accept) begin
      rrpv_rd <= rrpv_mem[set_index[ROW_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go && req.command == CMD_QUERY) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go && req.command == CMD_QUERY) begin
      victim_way <= result.victim;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/csrp_checker.sv
// ----------------------------------------------------------------------------
// Cache set replacement policy checker
// Port-level checks on request spacing, result timing and the reset sweep,
// bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cache_set_replacement_policy_macros.svh"

module csrp_checker
  import csrp_pkg::*;
(
  input wire                   clk,
  input wire                   rst,
  input wire                   in_valid,
  input wire                   in_ready,
  input wire                   command,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire [WAY_FIELD_W-1:0] victim_way
);

  `CSRP_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
                    out_valid && $stable(victim_way), "result dropped or changed while stalled")
  `CSRP_ASSERT_NEXT(a_request_spacing, in_valid && in_ready, !in_ready,
                    "request accepted in the cycle after another")
  `CSRP_ASSERT_NEXT(a_update_silent, in_valid && in_ready && command == CMD_UPDATE && !out_valid,
                    !out_valid, "update produced a result")
  `CSRP_ASSERT_SAME(a_sweep_after_reset, $past(rst), !in_ready,
                    "request taken before the reset sweep")

endmodule

bind cache_set_replacement_policy csrp_checker u_csrp_checker (.*);

`default_nettype wire
